[hw/rtl/slotted_page_record_store_defines.svh]
// assertion macros for the slotted page record store
// used by the sequencer module
`ifndef SLOTTED_PAGE_RECORD_STORE_DEFINES_SVH
`define SLOTTED_PAGE_RECORD_STORE_DEFINES_SVH

// implication checked on every clock edge outside reset
`define SPRS_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define SPRS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/sprs_pkg.sv]
// package for the slotted page record store: widths, codes, result word type
// no dependencies
`timescale 1ns / 1ps
package sprs_pkg;
   localparam int PageBytes   = 4096;
   localparam int HeaderBytes = 4;
   localparam int MaxRecords  = 1023;
   localparam int DirBytes    = 4;

   localparam int AddrW = 12;
   localparam int OffW  = 13;
   localparam int IdxW  = 10;
   localparam int FreeW = 12;

   localparam logic [1:0] REQ_ADD    = 2'd0;
   localparam logic [1:0] REQ_WRITE  = 2'd1;
   localparam logic [1:0] REQ_REMOVE = 2'd2;
   localparam logic [1:0] REQ_READ   = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NOSPACE = 2'd1;
   localparam logic [1:0] ST_BADIDX  = 2'd2;

   typedef struct packed {
      logic [1:0]      req_type;
      logic [OffW-1:0] obj_size;
      logic [IdxW-1:0] slot_index;
      logic [11:0]     byte_offset;
      logic [7:0]      data_byte;
   } req_word_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [IdxW-1:0]  result_index;
      logic [OffW-1:0]  obj_offset;
      logic [OffW-1:0]  record_size;
      logic [7:0]       read_byte;
      logic [IdxW-1:0]  entry_count;
      logic [FreeW-1:0] free_bytes;
   } rsp_word_type;

   // memory request from the sequencer to the page store
   typedef struct packed {
      logic             wr;
      logic [AddrW-1:0] waddr;
      logic [7:0]       wdata;
      logic [AddrW-1:0] raddr;
   } page_ctl_type;
endpackage

[hw/rtl/sprs_if.sv]
// valid/ready channel carrying one payload word
// depends on no other file
`timescale 1ns / 1ps
interface sprs_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[hw/rtl/slotted_page_record_store.sv]
// channel   dir  payload
// req       in   req_type obj_size slot_index byte_offset data_byte
// rsp       out  status result_index obj_offset record_size read_byte entry_count free_bytes
// add updates the directory at once, write/read look it up first; a last step posts the result
// removing a non-last record moves bytes and shifts directory entries by read and write steps
// after reset a clearing pass zeroes all 4096 page bytes before req is ready
// the one page ram port pair and the directory ram port set the step count
// depends on sprs_pkg, sprs_if, sprs_seq
`timescale 1ns / 1ps
module slotted_page_record_store (
   input logic clock,
   input logic reset,
   sprs_if.sink   req,
   sprs_if.source rsp
);
   import sprs_pkg::*;
   sprs_seq u_seq (
      .clock(clock), .reset(reset),
      .in_valid(req.valid), .in_ready(req.ready), .in_word(req.payload),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_word(rsp.payload)
   );
endmodule

[hw/rtl/sprs_page_ram.sv]
// page byte store: one write port, one registered read port
// depends on sprs_pkg
`timescale 1ns / 1ps
module sprs_page_ram (
   input  logic                  clock,
   input  sprs_pkg::page_ctl_type ctl,
   output logic [7:0]            rdata
);
   import sprs_pkg::*;
   logic [7:0] mem [PageBytes];
   always_ff @(posedge clock) begin
      if (ctl.wr) begin
         mem[ctl.waddr] <= ctl.wdata;
      end
      rdata <= mem[ctl.raddr];
   end
endmodule

[hw/rtl/sprs_seq.sv]
// sequencer: directory memory, clearing pass, request steps and remove moves
// depends on sprs_pkg, sprs_page_ram, the defines header
`timescale 1ns / 1ps
`include "slotted_page_record_store_defines.svh"
module sprs_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  sprs_pkg::req_word_type in_word,
   output logic                  out_valid,
   input  logic                  out_ready,
   output sprs_pkg::rsp_word_type out_word
);
   import sprs_pkg::*;

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_DIR1   = 4'd2;
   localparam logic [3:0] S_DIR2   = 4'd3;
   localparam logic [3:0] S_DIR3   = 4'd4;
   localparam logic [3:0] S_BYTE   = 4'd5;
   localparam logic [3:0] S_MVRD   = 4'd6;
   localparam logic [3:0] S_MVWR   = 4'd7;
   localparam logic [3:0] S_DRRD   = 4'd8;
   localparam logic [3:0] S_DRWR   = 4'd9;
   localparam logic [3:0] S_OUT    = 4'd10;

   logic [3:0] state_ff, state_in;
   logic [OffW-1:0] dir_mem [MaxRecords];
   logic [IdxW-1:0] draddr;
   logic [OffW-1:0] drdata;
   logic            dwr;
   logic [IdxW-1:0] dwaddr;
   logic [OffW-1:0] dwdata;

   always_ff @(posedge clock) begin
      if (dwr) begin
         dir_mem[dwaddr] <= dwdata;
      end
      drdata <= dir_mem[draddr];
   end

   page_ctl_type pctl;
   logic [7:0]   prdata;
   sprs_page_ram u_ram (.clock(clock), .ctl(pctl), .rdata(prdata));

   req_word_type    req_ff, req_in;
   rsp_word_type    rsp_ff, rsp_in;
   logic [IdxW-1:0] occ_ff, occ_in;
   logic [OffW-1:0] top_ff, top_in;     // start of the last record or page end
   logic [OffW-1:0] prev_ff, prev_in;   // end of the addressed record
   logic [OffW-1:0] offs_ff, offs_in;
   logic [OffW-1:0] ptr_ff, ptr_in;     // move address or directory index
   logic [AddrW:0]  clr_ff, clr_in;
   logic            pend_ff, pend_in;

   logic [OffW:0]    free_w;
   logic [OffW-1:0]  size_w;
   logic [OffW-1:0]  bufaddr;

   always_comb begin
      free_w = {1'b0, top_ff} - (OffW+1)'(HeaderBytes) - (OffW+1)'({occ_ff, 2'b00});
      if (free_w[OffW]) free_w = '0;
      size_w = (prev_ff >= offs_ff) ? prev_ff - offs_ff : '0;
      bufaddr = offs_ff + OffW'(req_ff.byte_offset);
   end

   assign in_ready  = (state_ff == S_IDLE) && !pend_ff;
   assign out_valid = (state_ff == S_IDLE) && pend_ff;
   assign out_word  = rsp_ff;

   always_comb begin
      state_in = state_ff;
      req_in   = req_ff;
      rsp_in   = rsp_ff;
      occ_in   = occ_ff;
      top_in   = top_ff;
      prev_in  = prev_ff;
      offs_in  = offs_ff;
      ptr_in   = ptr_ff;
      clr_in   = clr_ff;
      pend_in  = pend_ff;
      pctl     = '0;
      draddr   = '0;
      dwr      = 1'b0;
      dwaddr   = '0;
      dwdata   = '0;
      if (out_valid && out_ready) pend_in = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            pctl.wr    = 1'b1;
            pctl.waddr = clr_ff[AddrW-1:0];
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == (AddrW+1)'(PageBytes - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (in_valid && in_ready) begin
               req_in = in_word;
               rsp_in = '0;
               if (in_word.req_type == REQ_ADD) begin
                  if ({1'b0, in_word.obj_size} + (OffW+1)'(DirBytes) <= free_w &&
                      occ_ff < IdxW'(MaxRecords)) begin
                     offs_in = (top_ff >= in_word.obj_size) ?
                               top_ff - in_word.obj_size : '0;
                     dwr = 1'b1;
                     dwaddr = occ_ff;
                     dwdata = offs_in;
                     rsp_in.result_index = occ_ff;
                     rsp_in.obj_offset = offs_in;
                     rsp_in.record_size = in_word.obj_size;
                     top_in = offs_in;
                     occ_in = occ_ff + 1'b1;
                  end else begin
                     rsp_in.status = ST_NOSPACE;
                  end
                  state_in = S_OUT;
               end else if (in_word.slot_index >= occ_ff) begin
                  rsp_in.status = ST_BADIDX;
                  state_in = S_OUT;
               end else begin
                  draddr = in_word.slot_index;
                  state_in = S_DIR1;
               end
            end
         end
         S_DIR1: begin
            offs_in = drdata;
            prev_in = OffW'(PageBytes);
            draddr = req_ff.slot_index - 1'b1;
            state_in = (req_ff.slot_index == '0) ? S_DIR3 : S_DIR2;
         end
         S_DIR2: begin
            prev_in = drdata;
            state_in = S_DIR3;
         end
         S_DIR3: begin
            rsp_in.obj_offset = offs_ff;
            rsp_in.record_size = size_w;
            if (req_ff.req_type == REQ_REMOVE) begin
               if (req_ff.slot_index == occ_ff - 1'b1) begin
                  occ_in = occ_ff - 1'b1;
                  top_in = prev_ff;
                  state_in = S_OUT;
               end else begin
                  // move bytes [top, offs) up by size, highest first
                  ptr_in = offs_ff;
                  if (offs_ff == top_ff ||
                      {1'b0, top_ff} + {1'b0, size_w} + {1'b0, offs_ff - top_ff} >
                      (OffW+1)'(PageBytes)) begin
                     ptr_in = {3'b0, req_ff.slot_index};
                     state_in = S_DRRD;
                  end else begin
                     state_in = S_MVRD;
                  end
               end
            end else if (OffW'(req_ff.byte_offset) >= size_w ||
                         bufaddr >= OffW'(PageBytes)) begin
               rsp_in.status = ST_BADIDX;
               state_in = S_OUT;
            end else if (req_ff.req_type == REQ_WRITE) begin
               pctl.wr = 1'b1;
               pctl.waddr = bufaddr[AddrW-1:0];
               pctl.wdata = req_ff.data_byte;
               state_in = S_OUT;
            end else begin
               pctl.raddr = bufaddr[AddrW-1:0];
               state_in = S_BYTE;
            end
         end
         S_BYTE: begin
            rsp_in.read_byte = prdata;
            state_in = S_OUT;
         end
         S_MVRD: begin
            pctl.raddr = AddrW'(ptr_ff - 1'b1);
            state_in = S_MVWR;
         end
         S_MVWR: begin
            pctl.wr = 1'b1;
            pctl.waddr = AddrW'(ptr_ff - 1'b1 + rsp_ff.record_size);
            pctl.wdata = prdata;
            ptr_in = ptr_ff - 1'b1;
            if (ptr_in == top_ff) begin
               ptr_in = {3'b0, req_ff.slot_index};
               state_in = S_DRRD;
            end else begin
               state_in = S_MVRD;
            end
         end
         S_DRRD: begin
            draddr = IdxW'(ptr_ff + 1'b1);
            state_in = S_DRWR;
         end
         S_DRWR: begin
            dwr = 1'b1;
            dwaddr = IdxW'(ptr_ff);
            dwdata = drdata + rsp_ff.record_size;
            ptr_in = ptr_ff + 1'b1;
            if (IdxW'(ptr_in) == occ_ff - 1'b1) begin
               occ_in = occ_ff - 1'b1;
               top_in = dwdata;
               state_in = S_OUT;
            end else begin
               state_in = S_DRRD;
            end
         end
         S_OUT: begin
            rsp_in.entry_count = occ_ff;
            rsp_in.free_bytes = free_w[FreeW-1:0];
            pend_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         occ_ff   <= '0;
         top_ff   <= OffW'(PageBytes);
         clr_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         occ_ff   <= occ_in;
         top_ff   <= top_in;
         clr_ff   <= clr_in;
         pend_ff  <= pend_in;
      end
      req_ff  <= req_in;
      rsp_ff  <= rsp_in;
      prev_ff <= prev_in;
      offs_ff <= offs_in;
      ptr_ff  <= ptr_in;
   end

   `SPRS_ASSERT_IMP(a_occ_max, 1'b1, occ_ff <= IdxW'(MaxRecords), "occupancy overflow")
   `SPRS_ASSERT_IMP(a_ready_out, 1'b1, !(in_ready && out_valid), "ready while result pending")
   `SPRS_ASSERT_NEXT(a_out_idle, state_ff == S_OUT, pend_ff, "result not posted")
   `SPRS_ASSERT_IMP(a_top_floor, 1'b1, top_ff >= OffW'(HeaderBytes), "records below header")
endmodule
